/* design/ctc_pkg.sv */
package ctc_pkg;

  localparam int COLOR_BITS = 8;
  localparam int CFG_BITS   = 12;
  localparam int IDX_BITS   = 3;
  // wide enough for 20 * bound and for both color values
  localparam int CMP_BITS   = 18;

  // register indexes on the config port
  localparam logic [IDX_BITS-1:0] REG_U_ENABLE = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_V_ENABLE = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_BINARIZE = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_U_LOW    = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_U_HIGH   = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_V_LOW    = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_V_HIGH   = 3'd6;

  // division jobs run at frame end
  localparam int JOB_BITS = 3;
  localparam logic [JOB_BITS-1:0] JOB_ALL_X = 3'd0;
  localparam logic [JOB_BITS-1:0] JOB_ALL_Y = 3'd1;
  localparam logic [JOB_BITS-1:0] JOB_U_X   = 3'd2;
  localparam logic [JOB_BITS-1:0] JOB_U_Y   = 3'd3;
  localparam logic [JOB_BITS-1:0] JOB_V_X   = 3'd4;
  localparam logic [JOB_BITS-1:0] JOB_V_Y   = 3'd5;

  // color weights and bound scales
  localparam logic signed [CMP_BITS-1:0] K1  = 18'sd1;
  localparam logic signed [CMP_BITS-1:0] K2  = 18'sd2;
  localparam logic signed [CMP_BITS-1:0] K3  = 18'sd3;
  localparam logic signed [CMP_BITS-1:0] K5  = 18'sd5;
  localparam logic signed [CMP_BITS-1:0] K9  = 18'sd9;
  localparam logic signed [CMP_BITS-1:0] K10 = 18'sd10;
  localparam logic signed [CMP_BITS-1:0] K20 = 18'sd20;

  typedef struct packed {
    logic                       u_enable;
    logic                       v_enable;
    logic                       binarize_mode;
    logic signed [CFG_BITS-1:0] u_low;
    logic signed [CFG_BITS-1:0] u_high;
    logic signed [CFG_BITS-1:0] v_low;
    logic signed [CFG_BITS-1:0] v_high;
  } cfg_t;

  typedef struct packed {
    logic hit_u;
    logic hit_v;
  } hit_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* design/ctc_classify.sv */
module ctc_classify (
  input  ctc_pkg::cfg_t                    cfg,
  input  logic [ctc_pkg::COLOR_BITS-1:0]   red,
  input  logic [ctc_pkg::COLOR_BITS-1:0]   green,
  input  logic [ctc_pkg::COLOR_BITS-1:0]   blue,
  output ctc_pkg::hit_t                    hit
);
  import ctc_pkg::*;

  logic signed [CMP_BITS-1:0] r_s, g_s, b_s;
  logic signed [CMP_BITS-1:0] un, vn;
  logic signed [CMP_BITS-1:0] u_scale, v_scale;
  logic signed [CMP_BITS-1:0] u_lo, u_hi, v_lo, v_hi;

  always_comb begin
    r_s = CMP_BITS'(red);
    g_s = CMP_BITS'(green);
    b_s = CMP_BITS'(blue);
    un  = K5 * b_s - K2 * r_s - K3 * g_s;
    vn  = K10 * r_s - K9 * g_s - b_s;
    // binarize: 1x / 2x, statistics: 10x / 20x
    u_scale = cfg.binarize_mode ? K1 : K10;
    v_scale = cfg.binarize_mode ? K2 : K20;
    u_lo = u_scale * CMP_BITS'(cfg.u_low);
    u_hi = u_scale * CMP_BITS'(cfg.u_high);
    v_lo = v_scale * CMP_BITS'(cfg.v_low);
    v_hi = v_scale * CMP_BITS'(cfg.v_high);
    hit.hit_u = cfg.u_enable && (un > u_lo) && (un < u_hi);
    hit.hit_v = cfg.v_enable && (vn > v_lo) && (vn < v_hi);
  end

endmodule

/* design/ctc_divider.sv */
module ctc_divider #(
  parameter int DVD_BITS = 31,
  parameter int DVS_BITS = 22,
  parameter int QUO_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DVD_BITS-1:0]   dividend,
  input  logic [DVS_BITS-1:0]   divisor,
  output ctc_pkg::div_stat_t    stat,
  output logic [QUO_BITS-1:0]   quotient
);
  import ctc_pkg::*;

  localparam int STEP_W = $clog2(DVD_BITS + 1);

  logic                busy, done;
  logic [STEP_W-1:0]   step;
  logic [DVD_BITS-1:0] dvd;
  logic [DVS_BITS-1:0] dsr;
  logic [DVS_BITS-1:0] rem;
  logic [QUO_BITS-1:0] quo;
  logic                ovf;
  logic                zero_div;

  logic [DVS_BITS:0]   trial, diff;
  logic                ge;

  // one restoring step per cycle
  always_comb begin
    trial = {rem, dvd[DVD_BITS-1]};
    diff  = trial - {1'b0, dsr};
    ge    = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        step <= STEP_W'(DVD_BITS);
      end else if (busy) begin
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvd      <= dividend;
      dsr      <= divisor;
      rem      <= '0;
      quo      <= '0;
      ovf      <= 1'b0;
      zero_div <= (divisor == '0);
    end else if (busy) begin
      dvd <= {dvd[DVD_BITS-2:0], 1'b0};
      rem <= ge ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
      quo <= {quo[QUO_BITS-2:0], ge};
      ovf <= ovf | quo[QUO_BITS-1];
    end
  end

  // zero divisor gives 0, quotient past the coordinate range clamps
  assign quotient  = zero_div ? '0 : (ovf ? '1 : quo);
  assign stat.busy = busy;
  assign stat.done = done;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while still busy");

  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    (done && zero_div) |-> (quotient == '0))
    else $error("zero divisor gave nonzero quotient");

endmodule

/* design/color_threshold_centroid_core.sv */
// color threshold and centroid core
//
// input channel (in_valid / in_ready) takes one pixel word: red, green, blue,
// x_pos, y_pos and frame_end. each pixel gives exactly one result word on the
// output channel (out_valid / out_ready): the class mark, plus the per-class
// and overall centroids on the word of the frame's last pixel.
// config port: cfg_write with cfg_index / cfg_data writes one register in the
// same cycle, to be used only while no pixel is in flight.
// a normal pixel goes through capture, classify and accumulate, and hand-off in
// that order, and the core takes no new pixel until the last one is handed off.
// the last pixel of a frame also runs six divisions through one shared restoring
// divider, one quotient bit per cycle, between classify and hand-off.
// a finished result sits in the output register, and the next pixel is taken
// while it waits; a stalled receiver holds only the hand-off of the following
// pixel. reset clears config, accumulators and the output valid flag.
module color_threshold_centroid_core #(
  parameter int COORD_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  // config write port
  input  logic                                cfg_write,
  input  logic [ctc_pkg::IDX_BITS-1:0]        cfg_index,
  input  logic [ctc_pkg::CFG_BITS-1:0]        cfg_data,
  // pixel input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ctc_pkg::COLOR_BITS-1:0]      red,
  input  logic [ctc_pkg::COLOR_BITS-1:0]      green,
  input  logic [ctc_pkg::COLOR_BITS-1:0]      blue,
  input  logic [COORD_BITS-1:0]               x_pos,
  input  logic [COORD_BITS-1:0]               y_pos,
  input  logic                                frame_end,
  // result output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                mark,
  output logic                                result_last,
  output logic                                any_found,
  output logic [COORD_BITS-1:0]               center_x,
  output logic [COORD_BITS-1:0]               center_y,
  output logic                                u_valid,
  output logic [COORD_BITS-1:0]               u_center_x,
  output logic [COORD_BITS-1:0]               u_center_y,
  output logic                                v_valid,
  output logic [COORD_BITS-1:0]               v_center_x,
  output logic [COORD_BITS-1:0]               v_center_y
);
  import ctc_pkg::*;

  localparam int SUM_BITS = 3 * COORD_BITS;
  localparam int CNT_BITS = 2 * COORD_BITS + 1;
  // overall sums and counts carry one more bit
  localparam int DVD_BITS = SUM_BITS + 1;
  localparam int DVS_BITS = CNT_BITS + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CLASS = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  cfg_t cfg;

  // captured pixel
  logic [COLOR_BITS-1:0] red_r, green_r, blue_r;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic                  last_r;
  logic                  mark_r;

  // accumulators
  logic [SUM_BITS-1:0] u_sum_x, u_sum_y, v_sum_x, v_sum_y;
  logic [CNT_BITS-1:0] u_count, v_count;

  // frame results staged until the output register is free
  logic                  any_r, uv_r, vv_r;
  logic [COORD_BITS-1:0] q_all_x, q_all_y, q_u_x, q_u_y, q_v_x, q_v_y;

  // divider sequencing
  logic [JOB_BITS-1:0]   job;
  logic                  div_go;
  logic [DVD_BITS-1:0]   div_dvd;
  logic [DVS_BITS-1:0]   div_dvs;
  div_stat_t             div_stat;
  logic [COORD_BITS-1:0] div_quo;

  hit_t hit;
  logic out_free;

  function automatic logic [SUM_BITS-1:0] sat_sum(input logic [SUM_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
    logic [SUM_BITS:0] s;
    s = (SUM_BITS + 1)'(a) + (SUM_BITS + 1)'(b);
    return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
  endfunction

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] a);
    return (a == '1) ? a : a + CNT_BITS'(1);
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_U_ENABLE: cfg.u_enable      <= cfg_data[0];
        REG_V_ENABLE: cfg.v_enable      <= cfg_data[0];
        REG_BINARIZE: cfg.binarize_mode <= cfg_data[0];
        REG_U_LOW:    cfg.u_low         <= cfg_data;
        REG_U_HIGH:   cfg.u_high        <= cfg_data;
        REG_V_LOW:    cfg.v_low         <= cfg_data;
        REG_V_HIGH:   cfg.v_high        <= cfg_data;
        default: ;
      endcase
    end
  end

  ctc_classify u_classify (
    .cfg   (cfg),
    .red   (red_r),
    .green (green_r),
    .blue  (blue_r),
    .hit   (hit)
  );

  // operand select for the current division job
  always_comb begin
    case (job)
      JOB_ALL_X: begin
        div_dvd = DVD_BITS'(u_sum_x) + DVD_BITS'(v_sum_x);
        div_dvs = DVS_BITS'(u_count) + DVS_BITS'(v_count);
      end
      JOB_ALL_Y: begin
        div_dvd = DVD_BITS'(u_sum_y) + DVD_BITS'(v_sum_y);
        div_dvs = DVS_BITS'(u_count) + DVS_BITS'(v_count);
      end
      JOB_U_X: begin
        div_dvd = DVD_BITS'(u_sum_x);
        div_dvs = DVS_BITS'(u_count);
      end
      JOB_U_Y: begin
        div_dvd = DVD_BITS'(u_sum_y);
        div_dvs = DVS_BITS'(u_count);
      end
      JOB_V_X: begin
        div_dvd = DVD_BITS'(v_sum_x);
        div_dvs = DVS_BITS'(v_count);
      end
      default: begin
        div_dvd = DVD_BITS'(v_sum_y);
        div_dvs = DVS_BITS'(v_count);
      end
    endcase
  end

  ctc_divider #(
    .DVD_BITS (DVD_BITS),
    .DVS_BITS (DVS_BITS),
    .QUO_BITS (COORD_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_CLASS;
      S_CLASS: state_next = last_r ? S_DIV : S_DONE;
      S_DIV:   if (div_stat.done && job == JOB_V_Y) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      div_go <= 1'b0;
      job    <= JOB_ALL_X;
    end else begin
      state  <= state_next;
      div_go <= 1'b0;
      if (state == S_CLASS && last_r) begin
        div_go <= 1'b1;
        job    <= JOB_ALL_X;
      end else if (state == S_DIV && div_stat.done && job != JOB_V_Y) begin
        div_go <= 1'b1;
        job    <= job + JOB_BITS'(1);
      end
    end
  end

  // pixel capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      red_r   <= red;
      green_r <= green;
      blue_r  <= blue;
      x_r     <= x_pos;
      y_r     <= y_pos;
      last_r  <= frame_end;
    end
    if (state == S_CLASS) mark_r <= hit.hit_u || hit.hit_v;
  end

  // accumulate, then clear once the last division of a frame is in
  always_ff @(posedge clk) begin
    if (rst) begin
      u_sum_x <= '0;
      u_sum_y <= '0;
      u_count <= '0;
      v_sum_x <= '0;
      v_sum_y <= '0;
      v_count <= '0;
    end else if (state == S_CLASS) begin
      if (hit.hit_u) begin
        u_sum_x <= sat_sum(u_sum_x, x_r);
        u_sum_y <= sat_sum(u_sum_y, y_r);
        u_count <= sat_inc(u_count);
      end
      if (hit.hit_v) begin
        v_sum_x <= sat_sum(v_sum_x, x_r);
        v_sum_y <= sat_sum(v_sum_y, y_r);
        v_count <= sat_inc(v_count);
      end
    end else if (state == S_DIV && div_stat.done && job == JOB_V_Y) begin
      u_sum_x <= '0;
      u_sum_y <= '0;
      u_count <= '0;
      v_sum_x <= '0;
      v_sum_y <= '0;
      v_count <= '0;
    end
  end

  // stage quotients and flags
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_stat.done) begin
      case (job)
        JOB_ALL_X: q_all_x <= div_quo;
        JOB_ALL_Y: q_all_y <= div_quo;
        JOB_U_X:   q_u_x   <= div_quo;
        JOB_U_Y:   q_u_y   <= div_quo;
        JOB_V_X:   q_v_x   <= div_quo;
        default: begin
          q_v_y <= div_quo;
          any_r <= (u_count != '0) || (v_count != '0);
          uv_r  <= cfg.u_enable && (u_count != '0);
          vv_r  <= cfg.v_enable && (v_count != '0);
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      mark        <= mark_r;
      result_last <= last_r;
      any_found   <= last_r && any_r;
      center_x    <= (last_r && any_r) ? q_all_x : '0;
      center_y    <= (last_r && any_r) ? q_all_y : '0;
      u_valid     <= last_r && uv_r;
      u_center_x  <= (last_r && uv_r) ? q_u_x : '0;
      u_center_y  <= (last_r && uv_r) ? q_u_y : '0;
      v_valid     <= last_r && vv_r;
      v_center_x  <= (last_r && vv_r) ? q_v_x : '0;
      v_center_y  <= (last_r && vv_r) ? q_v_y : '0;
    end
  end

  a_cleared_after_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && last_r) |-> (u_count == '0 && v_count == '0))
    else $error("accumulators not cleared after frame end");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_go |-> (state == S_DIV))
    else $error("divider started outside the division phase");

  a_flags_only_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (u_valid || v_valid || any_found)) |-> result_last)
    else $error("centroid flag on a non-final word");

  a_none_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !any_found) |-> (center_x == '0 && center_y == '0))
    else $error("overall centroid nonzero with no pixels found");

endmodule

/* test/centroid_checker.sv */
`timescale 1ns / 100ps

module centroid_checker #(
  parameter int COORD_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ctc_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [ctc_pkg::CFG_BITS-1:0]   cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [ctc_pkg::COLOR_BITS-1:0] red,
  input  logic [ctc_pkg::COLOR_BITS-1:0] green,
  input  logic [ctc_pkg::COLOR_BITS-1:0] blue,
  input  logic [COORD_BITS-1:0]          x_pos,
  input  logic [COORD_BITS-1:0]          y_pos,
  input  logic                           frame_end,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           mark,
  input  logic                           result_last,
  input  logic                           any_found,
  input  logic [COORD_BITS-1:0]          center_x,
  input  logic [COORD_BITS-1:0]          center_y,
  input  logic                           u_valid,
  input  logic [COORD_BITS-1:0]          u_center_x,
  input  logic [COORD_BITS-1:0]          u_center_y,
  input  logic                           v_valid,
  input  logic [COORD_BITS-1:0]          v_center_x,
  input  logic [COORD_BITS-1:0]          v_center_y,
  output int                             fail_count,
  output int                             pending
);
  import ctc_pkg::*;

  localparam longint SUM_MAX   = (longint'(1) << (3 * COORD_BITS)) - 1;
  localparam longint COUNT_MAX = (longint'(1) << (2 * COORD_BITS + 1)) - 1;
  localparam longint COORD_MAX = (longint'(1) << COORD_BITS) - 1;

  typedef struct packed {
    logic                  mark;
    logic                  result_last;
    logic                  any_found;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic                  u_valid;
    logic [COORD_BITS-1:0] u_center_x;
    logic [COORD_BITS-1:0] u_center_y;
    logic                  v_valid;
    logic [COORD_BITS-1:0] v_center_x;
    logic [COORD_BITS-1:0] v_center_y;
  } result_word_t;

  cfg_t         cfg_shadow;
  longint       u_sum_x, u_sum_y, u_cnt;
  longint       v_sum_x, v_sum_y, v_cnt;
  result_word_t expected_words[$];

  function automatic void clear_sums();
    u_sum_x = 0; u_sum_y = 0; u_cnt = 0;
    v_sum_x = 0; v_sum_y = 0; v_cnt = 0;
  endfunction

  function automatic longint sat_add(longint a, longint b, longint max);
    return (a + b > max) ? max : a + b;
  endfunction

  function automatic logic [COORD_BITS-1:0] centroid_of(longint sum, longint cnt);
    longint q;
    if (cnt == 0) return '0;
    q = sum / cnt;
    if (q > COORD_MAX) q = COORD_MAX;
    return q[COORD_BITS-1:0];
  endfunction

  // classify one pixel, update the class sums and build its result word
  function automatic result_word_t predict_pixel(
    logic [COLOR_BITS-1:0] r, logic [COLOR_BITS-1:0] g, logic [COLOR_BITS-1:0] b,
    logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y, logic last);
    result_word_t w;
    int           un, vn, us, vs;
    logic         hit_u, hit_v;
    longint       total;
    un = 5 * int'(b) - 2 * int'(r) - 3 * int'(g);
    vn = 10 * int'(r) - 9 * int'(g) - int'(b);
    us = cfg_shadow.binarize_mode ? 1 : 10;
    vs = cfg_shadow.binarize_mode ? 2 : 20;
    hit_u = cfg_shadow.u_enable && un > us * int'($signed(cfg_shadow.u_low))
            && un < us * int'($signed(cfg_shadow.u_high));
    hit_v = cfg_shadow.v_enable && vn > vs * int'($signed(cfg_shadow.v_low))
            && vn < vs * int'($signed(cfg_shadow.v_high));
    if (hit_u) begin
      u_sum_x = sat_add(u_sum_x, longint'(x), SUM_MAX);
      u_sum_y = sat_add(u_sum_y, longint'(y), SUM_MAX);
      u_cnt   = sat_add(u_cnt, longint'(1), COUNT_MAX);
    end
    if (hit_v) begin
      v_sum_x = sat_add(v_sum_x, longint'(x), SUM_MAX);
      v_sum_y = sat_add(v_sum_y, longint'(y), SUM_MAX);
      v_cnt   = sat_add(v_cnt, longint'(1), COUNT_MAX);
    end
    w = '0;
    w.mark = hit_u || hit_v;
    if (last) begin
      total         = u_cnt + v_cnt;
      w.result_last = 1'b1;
      w.any_found   = total > 0;
      w.center_x    = centroid_of(u_sum_x + v_sum_x, total);
      w.center_y    = centroid_of(u_sum_y + v_sum_y, total);
      w.u_valid     = cfg_shadow.u_enable && u_cnt > 0;
      w.v_valid     = cfg_shadow.v_enable && v_cnt > 0;
      if (w.u_valid) begin
        w.u_center_x = centroid_of(u_sum_x, u_cnt);
        w.u_center_y = centroid_of(u_sum_y, u_cnt);
      end
      if (w.v_valid) begin
        w.v_center_x = centroid_of(v_sum_x, v_cnt);
        w.v_center_y = centroid_of(v_sum_y, v_cnt);
      end
      clear_sums();
    end
    return w;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : track
    result_word_t got, want;
    if (rst) begin
      cfg_shadow = '0;
      clear_sums();
      expected_words.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_U_ENABLE: cfg_shadow.u_enable      = cfg_data[0];
          REG_V_ENABLE: cfg_shadow.v_enable      = cfg_data[0];
          REG_BINARIZE: cfg_shadow.binarize_mode = cfg_data[0];
          REG_U_LOW:    cfg_shadow.u_low         = cfg_data;
          REG_U_HIGH:   cfg_shadow.u_high        = cfg_data;
          REG_V_LOW:    cfg_shadow.v_low         = cfg_data;
          REG_V_HIGH:   cfg_shadow.v_high        = cfg_data;
          default: ;
        endcase
      end
      // result before pixel: a word leaving now can never belong to a pixel entering now
      if (out_valid && out_ready) begin
        got = {mark, result_last, any_found, center_x, center_y, u_valid, u_center_x,
               u_center_y, v_valid, v_center_x, v_center_y};
        if (expected_words.size() == 0) begin
          $display("%0t: result word with nothing expected, got %h", $time, got);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("mark", 32'(want.mark), 32'(got.mark));
          check_field("result_last", 32'(want.result_last), 32'(got.result_last));
          check_field("any_found", 32'(want.any_found), 32'(got.any_found));
          check_field("center_x", 32'(want.center_x), 32'(got.center_x));
          check_field("center_y", 32'(want.center_y), 32'(got.center_y));
          check_field("u_valid", 32'(want.u_valid), 32'(got.u_valid));
          check_field("u_center_x", 32'(want.u_center_x), 32'(got.u_center_x));
          check_field("u_center_y", 32'(want.u_center_y), 32'(got.u_center_y));
          check_field("v_valid", 32'(want.v_valid), 32'(got.v_valid));
          check_field("v_center_x", 32'(want.v_center_x), 32'(got.v_center_x));
          check_field("v_center_y", 32'(want.v_center_y), 32'(got.v_center_y));
        end
      end
      if (in_valid && in_ready) begin
        expected_words.push_back(predict_pixel(red, green, blue, x_pos, y_pos, frame_end));
      end
    end
    pending <= expected_words.size();
  end

endmodule

/* test/tb_color_threshold_centroid_core.sv */
`timescale 1ns / 100ps

module tb_color_threshold_centroid_core;
  import ctc_pkg::*;

  localparam int COORD_BITS     = 10;
  localparam int RANDOM_ITEMS   = 480;
  localparam int TAIL_ITEMS     = 60;    // final stretch with no idling anywhere
  localparam int PRESSURE_AT    = 150;   // result words seen before the long receiver hold
  localparam int LONG_HOLD      = 300;
  // slowest legal gap: long hold plus a frame-end division pass plus bursts, several times over
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [IDX_BITS-1:0]   cfg_index;
  logic [CFG_BITS-1:0]   cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [COLOR_BITS-1:0] red, green, blue;
  logic [COORD_BITS-1:0] x_pos, y_pos;
  logic                  frame_end;
  logic                  out_valid;
  logic                  out_ready;
  logic                  mark, result_last, any_found;
  logic [COORD_BITS-1:0] center_x, center_y;
  logic                  u_valid, v_valid;
  logic [COORD_BITS-1:0] u_center_x, u_center_y, v_center_x, v_center_y;

  int fail_count;
  int pending;
  int out_words = 0;
  bit quiet_tail = 1'b0;   // set for the last part: no idling on either side
  bit sender_gaps = 1'b1;  // per phase: does the pixel source idle at all
  bit squeezed = 1'b0;     // long receiver hold already done

  always #5 clk = ~clk;

  color_threshold_centroid_core #(.COORD_BITS(COORD_BITS)) uut (.*);

  centroid_checker #(.COORD_BITS(COORD_BITS)) checker_i (.*);

  // result words seen, drives the timing of the long hold
  always @(posedge clk) begin
    if (rst) begin
      out_words <= 0;
    end else if (out_valid && out_ready) begin
      out_words <= out_words + 1;
    end
  end

  // ends the run if nothing moves on either channel for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  // result side: ready stretches broken by stall bursts, plus one long hold so the
  // core backs up and drops in_ready while pixels keep coming
  initial begin : receiver
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!squeezed && out_words >= PRESSURE_AT && in_valid) begin
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
    end
  end

  // stop offering pixels and let every expected word come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // full register set, only once the core is idle
  task automatic set_cfg(input int ue, input int ve, input int bm, input int ul,
                         input int uh, input int vl, input int vh);
    wait_drained();
    write_reg(REG_U_ENABLE, CFG_BITS'(ue));
    write_reg(REG_V_ENABLE, CFG_BITS'(ve));
    write_reg(REG_BINARIZE, CFG_BITS'(bm));
    write_reg(REG_U_LOW, CFG_BITS'(ul));
    write_reg(REG_U_HIGH, CFG_BITS'(uh));
    write_reg(REG_V_LOW, CFG_BITS'(vl));
    write_reg(REG_V_HIGH, CFG_BITS'(vh));
    cfg_write <= 1'b0;
  endtask

  // offer one pixel word and hold it until taken; valid stays up for the next word
  task automatic send_pixel(input int r, input int g, input int b, input int x, input int y,
                            input bit last);
    if (sender_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    red       <= r[COLOR_BITS-1:0];
    green     <= g[COLOR_BITS-1:0];
    blue      <= b[COLOR_BITS-1:0];
    x_pos     <= x[COORD_BITS-1:0];
    y_pos     <= y[COORD_BITS-1:0];
    frame_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin : stimulus
    int sent, n, lo, hi, vlo, vhi;
    bit bm;
    int ue, ve, bmw, ul, uh, vl, vh;

    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    red       <= '0;
    green     <= '0;
    blue      <= '0;
    x_pos     <= '0;
    y_pos     <= '0;
    frame_end <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // widest bounds: every pixel lands in both classes, color and coordinate extremes
    set_cfg(1, 1, 1, -2048, 2047, -2048, 2047);
    send_pixel(0, 0, 0, 0, 0, 0);
    send_pixel(255, 255, 255, 1023, 1023, 0);
    send_pixel(255, 0, 0, 1023, 0, 0);
    send_pixel(0, 255, 0, 0, 1023, 0);
    send_pixel(0, 0, 255, 512, 512, 1);

    // inverted bounds: empty frame, zero counts give zero centroids
    set_cfg(1, 1, 1, 2047, -2048, 2047, -2048);
    send_pixel(17, 99, 200, 5, 6, 1);

    // binarize scaling, values sitting exactly on the bounds are excluded
    set_cfg(1, 1, 1, -2, 5, 0, 5);
    send_pixel(1, 0, 0, 10, 20, 0);
    send_pixel(0, 0, 1, 30, 40, 0);
    send_pixel(0, 1, 1, 50, 60, 0);
    send_pixel(1, 0, 1, 70, 80, 1);

    // statistics scaling, same edge checks at the x10 / x20 bounds; mark still reported
    set_cfg(1, 1, 0, 0, 1, 0, 1);
    send_pixel(0, 0, 2, 100, 200, 0);
    send_pixel(0, 0, 1, 300, 400, 0);
    send_pixel(2, 0, 0, 500, 600, 0);
    send_pixel(1, 0, 1, 700, 800, 1);

    // u class fills mid-frame, then gets disabled before the frame ends:
    // its sums still feed the overall centroid but u_valid drops
    set_cfg(1, 0, 1, -2048, 2047, -2048, 2047);
    send_pixel(10, 20, 30, 1000, 3, 0);
    send_pixel(200, 100, 50, 900, 7, 0);
    send_pixel(0, 0, 0, 800, 11, 0);
    set_cfg(0, 1, 1, -2048, 2047, -2048, 2047);
    send_pixel(40, 50, 60, 2, 1020, 0);
    send_pixel(90, 10, 5, 4, 1010, 1);

    // random phases; a phase boundary may fall mid-frame
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      bm  = 1'($urandom_range(0, 1));
      lo  = int'($urandom_range(0, 2000)) - 1300;
      hi  = lo + int'($urandom_range(0, 1300));
      vlo = int'($urandom_range(0, 4000)) - 2600;
      vhi = vlo + int'($urandom_range(0, 2600));
      if (bm) begin
        ul = lo;
        uh = hi;
        vl = vlo / 2;
        vh = vhi / 2;
      end else begin
        ul = lo / 10;
        uh = hi / 10;
        vl = vlo / 20;
        vh = vhi / 20;
      end
      // now and then any bounds at all, often empty or inverted
      if ($urandom_range(0, 7) == 0) begin
        ul = $urandom;
        uh = $urandom;
      end
      if ($urandom_range(0, 7) == 0) begin
        vl = $urandom;
        vh = $urandom;
      end
      // single-bit registers get junk in the upper data bits
      ue     = $urandom;
      ue[0]  = ($urandom_range(0, 7) != 0);
      ve     = $urandom;
      ve[0]  = ($urandom_range(0, 7) != 0);
      bmw    = $urandom;
      bmw[0] = bm;
      if (sent >= RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
      set_cfg(ue, ve, bmw, ul, uh, vl, vh);
      sender_gaps = ($urandom_range(0, 3) != 0);
      n = $urandom_range(15, 60);
      repeat (n) begin
        send_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 11) == 0);
        sent++;
      end
    end
    // close the open frame so its centroids are checked too
    send_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 1023), $urandom_range(0, 1023), 1);

    wait_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
